// ===== rtl/dprs_pkg.sv =====
// dprs_pkg: shared types and constants for the dirty page range scanner
// no dependencies; imported by dprs_find and dirty_page_range_scanner
`default_nettype none

package dprs_pkg;

  // flags held in one row of the dirty table
  localparam int WORD_BITS = 64;
  localparam int BIT_W     = 6;

  // result address width
  localparam int ADDR_W = 48;

  // operation codes on in_op
  localparam logic OP_MARK  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARK,
    ST_LOAD,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // lowest set flag of a row
  typedef struct packed {
    logic             any;
    logic [BIT_W-1:0] idx;
  } find_res_t;

endpackage

`default_nettype wire

// ===== rtl/dprs_find.sv =====
// dprs_find: priority encoder that finds the lowest set flag in one table row
// depends on dprs_pkg
`default_nettype none

module dprs_find (
  input  wire logic [dprs_pkg::WORD_BITS-1:0] vec,
  output dprs_pkg::find_res_t                 res
);
  import dprs_pkg::*;

  // scan from the top so the lowest set bit wins
  always_comb begin
    res.any = |vec;
    res.idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (vec[i]) begin
        res.idx = BIT_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dirty_page_range_scanner.sv =====
// dirty_page_range_scanner: dirty flag table with a range scan sequencer
// depends on dprs_pkg and dprs_find
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   op, page_index, region_pages,
//                                             report_limit, clear_dirty
//   out_     output     out_valid / out_stall page_address, found,
//                                             report_count, last
//   cfg_     input      cfg_wr_en             cfg_wr_data (heap base address)
//
// a mark word reads its row, then writes the row back with the flag set
// a query loads each 64-page row it touches, reports the found pages of
// the row one at a time, writes the row back and stops early when the
// report limit is reached; the table memory has separate read and write
// ports and a registered read
// after reset the table is swept clear, one row per cycle, with in_stall
// held high; cfg writes are taken at any time
// a stalled output holds the scan on the next found page
`default_nettype none

module dirty_page_range_scanner #(
  parameter int TABLE_PAGES = 4096,
  parameter int MAX_REPORT  = 64,
  parameter int PAGE_SHIFT  = 12
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        cfg_wr_en,
  input  wire logic [47:0] cfg_wr_data,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_op,
  input  wire logic [11:0] in_page_index,
  input  wire logic [12:0] in_region_pages,
  input  wire logic [6:0]  in_report_limit,
  input  wire logic        in_clear_dirty,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [47:0]      out_page_address,
  output logic             out_found,
  output logic [6:0]       out_report_count,
  output logic             out_last
);
  import dprs_pkg::*;

  localparam int ROWS  = TABLE_PAGES / WORD_BITS;
  localparam int PG_W  = $clog2(TABLE_PAGES);
  localparam int ROW_W = (PG_W > BIT_W) ? PG_W - BIT_W : 1;
  localparam int EXT_W = ((PG_W + 1) > 13 ? PG_W + 1 : 13) + 1;
  localparam logic [EXT_W-1:0] TP_EXT    = EXT_W'(TABLE_PAGES);
  localparam logic [6:0]       MAX_LIM   = 7'(MAX_REPORT);
  localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);

  // sequencer and scan registers
  state_t                 state_r, state_nxt;
  logic [ROW_W-1:0]       row_r, row_nxt;
  logic [ROW_W-1:0]       first_row_r, first_row_nxt;
  logic [ROW_W-1:0]       last_row_r, last_row_nxt;
  logic [BIT_W-1:0]       lo_r, lo_nxt;
  logic [BIT_W-1:0]       hi_r, hi_nxt;
  logic [WORD_BITS-1:0]   word_r, word_nxt;
  logic [WORD_BITS-1:0]   cand_r, cand_nxt;
  logic                   clear_r, clear_nxt;
  logic [6:0]             limit_r, limit_nxt;
  logic [6:0]             count_r, count_nxt;
  logic [BIT_W-1:0]       mark_bit_r, mark_bit_nxt;
  logic [47:0]            base_r;

  // held report waiting to learn whether it is the last
  logic                   pend_valid_r, pend_valid_nxt;
  logic [PG_W-1:0]        pend_page_r, pend_page_nxt;
  logic [6:0]             pend_count_r, pend_count_nxt;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  logic [47:0]            out_addr_r, out_addr_nxt;
  logic                   out_found_r, out_found_nxt;
  logic [6:0]             out_count_r, out_count_nxt;
  logic                   out_last_r, out_last_nxt;

  // table memory ports
  logic [WORD_BITS-1:0]   mem [ROWS];
  logic [WORD_BITS-1:0]   mem_q;
  logic                   mem_re, mem_we;
  logic [ROW_W-1:0]       mem_ra, mem_wa;
  logic [WORD_BITS-1:0]   mem_wd;

  // query decode
  logic                   in_acc;
  logic [EXT_W-1:0]       q_start_raw, q_start, q_sum, q_end, q_last_pg;
  logic                   q_empty;
  logic [6:0]             q_limit;
  logic                   q_go;
  logic                   mark_ok;

  // scan helpers
  find_res_t              fres;
  logic                   out_free;
  logic                   hit_step;
  logic [6:0]             cnt_inc;
  logic                   limit_hit;
  logic [WORD_BITS-1:0]   hit_mask;
  logic [WORD_BITS-1:0]   range_mask;
  logic [47:0]            pend_addr;

  dprs_find u_find (
    .vec (cand_r),
    .res (fres)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // clip range and limit of an incoming query
  always_comb begin
    q_start_raw = EXT_W'(in_page_index);
    q_start     = (q_start_raw >= TP_EXT) ? TP_EXT : q_start_raw;
    q_sum       = q_start + EXT_W'(in_region_pages);
    q_end       = (q_sum > TP_EXT) ? TP_EXT : q_sum;
    q_last_pg   = q_end - EXT_W'(1);
    q_empty     = (q_end == q_start);
    q_limit     = (in_report_limit > MAX_LIM) ? MAX_LIM : in_report_limit;
    q_go        = !q_empty && (q_limit != 7'd0);
    mark_ok     = (q_start_raw < TP_EXT);
  end

  // flags of the loaded row that lie inside the range
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      range_mask[i] = ((row_r != first_row_r) || (BIT_W'(i) >= lo_r)) &&
                      ((row_r != last_row_r) || (BIT_W'(i) <= hi_r));
    end
  end

  // one report step of the scan
  always_comb begin
    hit_step  = fres.any && (!pend_valid_r || out_free);
    cnt_inc   = count_r + 7'd1;
    limit_hit = (cnt_inc == limit_r);
    hit_mask  = {{(WORD_BITS-1){1'b0}}, 1'b1} << fres.idx;
    pend_addr = base_r + (ADDR_W'(pend_page_r) << PAGE_SHIFT);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (row_r == LAST_ROW) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_MARK) begin
            if (mark_ok) state_nxt = ST_MARK;
          end else if (q_go) begin
            state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_MARK:  state_nxt = ST_IDLE;
      ST_LOAD:  state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (fres.any) begin
          if (hit_step && limit_hit) state_nxt = ST_FLUSH;
        end else if (row_r == last_row_r) begin
          state_nxt = ST_FLUSH;
        end else begin
          state_nxt = ST_LOAD;
        end
      end
      ST_FLUSH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    row_nxt        = row_r;
    first_row_nxt  = first_row_r;
    last_row_nxt   = last_row_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    word_nxt       = word_r;
    cand_nxt       = cand_r;
    clear_nxt      = clear_r;
    limit_nxt      = limit_r;
    count_nxt      = count_r;
    mark_bit_nxt   = mark_bit_r;
    pend_valid_nxt = pend_valid_r;
    pend_page_nxt  = pend_page_r;
    pend_count_nxt = pend_count_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_addr_nxt   = out_addr_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    mem_re         = 1'b0;
    mem_ra         = row_r;
    mem_we         = 1'b0;
    mem_wa         = row_r;
    mem_wd         = word_r;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        mem_wd  = '0;
        row_nxt = ROW_W'(row_r + 1'b1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_MARK) begin
            mem_re       = mark_ok;
            mem_ra       = ROW_W'(q_start_raw >> BIT_W);
            row_nxt      = mem_ra;
            mark_bit_nxt = in_page_index[BIT_W-1:0];
          end else begin
            first_row_nxt  = ROW_W'(q_start >> BIT_W);
            last_row_nxt   = ROW_W'(q_last_pg >> BIT_W);
            lo_nxt         = q_start[BIT_W-1:0];
            hi_nxt         = q_last_pg[BIT_W-1:0];
            row_nxt        = first_row_nxt;
            clear_nxt      = in_clear_dirty;
            limit_nxt      = q_limit;
            count_nxt      = 7'd0;
            pend_valid_nxt = 1'b0;
            mem_re         = q_go;
            mem_ra         = first_row_nxt;
          end
        end
      end
      ST_MARK: begin
        mem_we = 1'b1;
        mem_wd = mem_q | ({{(WORD_BITS-1){1'b0}}, 1'b1} << mark_bit_r);
      end
      ST_LOAD: begin
        word_nxt = mem_q;
        cand_nxt = mem_q & range_mask;
      end
      ST_SCAN: begin
        if (fres.any) begin
          if (hit_step) begin
            cand_nxt = cand_r & ~hit_mask;
            if (clear_r) word_nxt = word_r & ~hit_mask;
            count_nxt = cnt_inc;
            // older report goes out, newer one is held
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_addr_nxt  = pend_addr;
              out_found_nxt = 1'b1;
              out_count_nxt = pend_count_r;
              out_last_nxt  = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_page_nxt  = PG_W'({row_r, fres.idx});
            pend_count_nxt = cnt_inc;
            if (limit_hit) begin
              mem_we = 1'b1;
              mem_wd = word_nxt;
            end
          end
        end else begin
          // row done: write it back and fetch the next one, if the range has one
          mem_we = 1'b1;
          mem_wd = word_r;
          if (row_r != last_row_r) begin
            row_nxt = ROW_W'(row_r + 1'b1);
            mem_re  = 1'b1;
            mem_ra  = row_nxt;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = pend_valid_r ? pend_addr : '0;
          out_found_nxt  = pend_valid_r;
          out_count_nxt  = pend_valid_r ? pend_count_r : 7'd0;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // dirty table memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_q <= mem[mem_ra];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      row_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      base_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      row_r        <= row_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) base_r <= cfg_wr_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    first_row_r  <= first_row_nxt;
    last_row_r   <= last_row_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    word_r       <= word_nxt;
    cand_r       <= cand_nxt;
    clear_r      <= clear_nxt;
    limit_r      <= limit_nxt;
    count_r      <= count_nxt;
    mark_bit_r   <= mark_bit_nxt;
    pend_page_r  <= pend_page_nxt;
    pend_count_r <= pend_count_nxt;
    out_addr_r   <= out_addr_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_page_address = out_addr_r;
  assign out_found        = out_found_r;
  assign out_report_count = out_count_r;
  assign out_last         = out_last_r;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking bench for dirty_page_range_scanner
// depends on dprs_pkg and the scanner rtl; keeps its own flag table to predict each result word

module tb_top;
  import dprs_pkg::*;

  localparam int TABLE_PAGES = 4096;
  localparam int MAX_REPORT  = 64;
  localparam int PAGE_SHIFT  = 12;

  // quiet time after the last result before a register write (lets a pending mark finish)
  localparam int SETTLE_CYCLES = 16;
  // watch for stray words after the run, longer than one full table scan
  localparam int END_CYCLES    = 200;
  localparam int CYCLE_LIMIT   = 1000000;

  localparam logic [ADDR_W-1:0] BASE_MAX = '1;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PATTERN
  } stall_mode_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic              found;
    logic [6:0]        count;
    logic              last;
  } page_report_t;

  // clock, reset and ports
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [47:0]       cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_op = OP_MARK;
  logic [11:0]       in_page_index = '0;
  logic [12:0]       in_region_pages = '0;
  logic [6:0]        in_report_limit = '0;
  logic              in_clear_dirty = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [47:0]       out_page_address;
  logic              out_found;
  logic [6:0]        out_report_count;
  logic              out_last;

  // predictor state
  bit                dirty_flags [TABLE_PAGES];
  logic [ADDR_W-1:0] heap_base = '0;
  page_report_t      pending_reports [$];
  int unsigned       mismatches = 0;
  int unsigned       cycle_count = 0;

  // sender and receiver idling controls
  bit                bursty = 1'b1;
  int unsigned       burst_left = 0;
  stall_mode_t       stall_mode = STALL_RANDOM;
  int unsigned       stall_pct = 25;
  logic [7:0]        stall_mask = 8'b0110_1010;
  int unsigned       stall_phase = 0;
  int unsigned       hold_request = 0;
  int unsigned       hold_left = 0;

  dirty_page_range_scanner #(
    .TABLE_PAGES (TABLE_PAGES),
    .MAX_REPORT  (MAX_REPORT),
    .PAGE_SHIFT  (PAGE_SHIFT)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_page_index    (in_page_index),
    .in_region_pages  (in_region_pages),
    .in_report_limit  (in_report_limit),
    .in_clear_dirty   (in_clear_dirty),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_page_address (out_page_address),
    .out_found        (out_found),
    .out_report_count (out_report_count),
    .out_last         (out_last)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL dirty_page_range_scanner");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    mismatches++;
  endtask

  // mark sets one flag; a query walks the range and queues the words it reports
  task automatic predict_word(input logic op, input logic [11:0] pg,
                              input logic [12:0] np, input logic [6:0] lim,
                              input logic clr);
    int unsigned  cap;
    int unsigned  first;
    int unsigned  stop;
    int unsigned  idx;
    page_report_t hit;
    page_report_t batch [$];
    if (op == OP_MARK) begin
      if (pg < TABLE_PAGES) dirty_flags[pg] = 1'b1;
    end else begin
      cap = (lim > MAX_REPORT) ? MAX_REPORT : lim;
      first = (pg >= TABLE_PAGES) ? TABLE_PAGES : pg;
      stop = first + np;
      if (stop > TABLE_PAGES) stop = TABLE_PAGES;
      for (idx = first; idx < stop && batch.size() < cap; idx++) begin
        if (dirty_flags[idx]) begin
          if (clr) dirty_flags[idx] = 1'b0;
          hit.addr = heap_base + (ADDR_W'(idx) << PAGE_SHIFT);
          hit.found = 1'b1;
          hit.count = 7'(batch.size() + 1);
          hit.last = 1'b0;
          batch.push_back(hit);
        end
      end
      // nothing reported gives one empty closing word
      if (batch.size() == 0) begin
        hit.addr = '0;
        hit.found = 1'b0;
        hit.count = '0;
        hit.last = 1'b1;
        batch.push_back(hit);
      end else begin
        batch[batch.size() - 1].last = 1'b1;
      end
      foreach (batch[k]) pending_reports.push_back(batch[k]);
    end
  endtask

  // offer one word, called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input logic op, input logic [11:0] pg, input logic [12:0] np,
                           input logic [6:0] lim, input logic clr);
    if (burst_left == 0) begin
      if (bursty) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_op           <= op;
    in_page_index   <= pg;
    in_region_pages <= np;
    in_report_limit <= lim;
    in_clear_dirty  <= clr;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_word(op, pg, np, lim, clr);
    @(negedge clk);
  endtask

  // drop valid, wait for every expected word, then let a pending mark finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_heap_base(input logic [ADDR_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    heap_base = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [ADDR_W-1:0] random_base();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[ADDR_W-1:0];
  endfunction

  // one random word, mostly aimed at a hot window so queries find dirty pages
  task automatic send_random(input int unsigned hot_lo, input int unsigned hot_span);
    logic        op;
    logic [11:0] pg;
    logic [12:0] np;
    logic [6:0]  lim;
    logic        clr;
    int unsigned pick;
    op = ($urandom_range(0, 99) < 62) ? OP_MARK : OP_QUERY;
    if ($urandom_range(0, 99) < 85)
      pg = 12'((hot_lo + $urandom_range(0, hot_span - 1)) % TABLE_PAGES);
    else
      pg = 12'($urandom_range(0, TABLE_PAGES - 1));
    pick = $urandom_range(0, 99);
    if (pick < 65) np = 13'($urandom_range(0, hot_span));
    else if (pick < 85) np = 13'($urandom_range(0, 8191));
    else if (pick < 95) np = 13'(TABLE_PAGES);
    else np = '0;
    pick = $urandom_range(0, 99);
    if (pick < 75) lim = 7'($urandom_range(1, MAX_REPORT));
    else if (pick < 85) lim = '0;
    else lim = 7'($urandom_range(MAX_REPORT + 1, 127));
    clr = ($urandom_range(0, 99) < 40);
    send_word(op, pg, np, lim, clr);
  endtask

  // receiver: long hold when asked, otherwise its own stall pattern
  always @(negedge clk) begin : drive_receiver
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE: begin
          out_stall <= 1'b0;
        end
        STALL_RANDOM: begin
          out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
        default: begin
          out_stall <= stall_mask[stall_phase % 8];
        end
      endcase
      stall_phase++;
    end
  end

  // compare each accepted result word with the oldest expectation
  always @(posedge clk) begin : check_results
    page_report_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("result word with none expected", out_page_address, '0);
      end else begin
        want = pending_reports.pop_front();
        if (out_page_address !== want.addr)
          report_mismatch("page_address", out_page_address, want.addr);
        if (out_found !== want.found)
          report_mismatch("found", 48'(out_found), 48'(want.found));
        if (out_report_count !== want.count)
          report_mismatch("report_count", 48'(out_report_count), 48'(want.count));
        if (out_last !== want.last)
          report_mismatch("last", 48'(out_last), 48'(want.last));
      end
    end
  end

  // queries on a clean table and an empty range
  task automatic test_empty_table();
    send_word(OP_QUERY, 12'd0, 13'd4096, 7'd64, 1'b0);
    send_word(OP_QUERY, 12'd100, 13'd0, 7'd64, 1'b1);
    wait_idle();
  endtask

  // marks at both table ends and row edges, zero limit, limit stop, range past end
  task automatic test_mark_and_report();
    send_word(OP_MARK, 12'd0, 13'd0, 7'd0, 1'b0);
    send_word(OP_MARK, 12'd4095, 13'd8191, 7'd127, 1'b1);
    send_word(OP_MARK, 12'd1, 13'd0, 7'd0, 1'b0);
    send_word(OP_MARK, 12'd63, 13'd0, 7'd0, 1'b0);
    send_word(OP_MARK, 12'd64, 13'd0, 7'd0, 1'b0);
    send_word(OP_MARK, 12'd64, 13'd0, 7'd0, 1'b0);
    send_word(OP_QUERY, 12'd0, 13'd4096, 7'd0, 1'b1);
    send_word(OP_QUERY, 12'd0, 13'd4096, 7'd64, 1'b0);
    send_word(OP_QUERY, 12'd1, 13'd8191, 7'd2, 1'b0);
    wait_idle();
  endtask

  // reported flags are cleared only when asked; oversized limit is capped
  task automatic test_clear_on_report();
    send_word(OP_QUERY, 12'd0, 13'd1, 7'd1, 1'b1);
    send_word(OP_QUERY, 12'd4095, 13'd4096, 7'd127, 1'b1);
    send_word(OP_QUERY, 12'd0, 13'd4096, 7'd64, 1'b1);
    send_word(OP_QUERY, 12'd0, 13'd4096, 7'd64, 1'b0);
    wait_idle();
  endtask

  // top base address wraps the page address past 2^48
  task automatic test_address_wrap();
    write_heap_base(BASE_MAX);
    send_word(OP_MARK, 12'd4095, 13'd0, 7'd0, 1'b0);
    send_word(OP_MARK, 12'd0, 13'd0, 7'd0, 1'b0);
    send_word(OP_QUERY, 12'd0, 13'd4096, 7'd64, 1'b1);
    wait_idle();
  endtask

  // random traffic in phases with different base addresses and idling
  task automatic test_random_traffic();
    int unsigned hot_lo;
    int unsigned hot_span;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_heap_base(random_base());
          bursty = 1'b1;
          stall_mode = STALL_RANDOM;
          stall_pct = 30;
        end
        1: begin
          write_heap_base(BASE_MAX);
          bursty = 1'b0;
          stall_mode = STALL_NONE;
        end
        2: begin
          write_heap_base('0);
          bursty = 1'b1;
          stall_mode = STALL_PATTERN;
          stall_mask = 8'($urandom) & 8'b1111_1110;
        end
        default: begin
          write_heap_base(random_base());
          bursty = 1'b1;
          stall_mode = STALL_RANDOM;
          stall_pct = 60;
        end
      endcase
      hot_lo = $urandom_range(0, TABLE_PAGES - 1);
      hot_span = 64 << $urandom_range(0, 3);
      repeat (70) send_random(hot_lo, hot_span);
      wait_idle();
    end
  endtask

  // receiver holds off while queries with many hits pile up behind it
  task automatic test_backpressure();
    int unsigned first;
    write_heap_base(random_base());
    bursty = 1'b0;
    stall_mode = STALL_NONE;
    hold_request = 600;
    first = $urandom_range(0, TABLE_PAGES - 128);
    for (int r = 0; r < 5; r++) begin
      for (int m = 0; m < 20; m++)
        send_word(OP_MARK, 12'(first + r * 20 + m), 13'($urandom), 7'($urandom), 1'b0);
      send_word(OP_QUERY, 12'(first), 13'(TABLE_PAGES), 7'd127, (r == 4));
    end
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_heap_base(48'h0000_0012_3456_7000);
    test_empty_table();
    test_mark_and_report();
    test_clear_on_report();
    test_address_wrap();
    test_random_traffic();
    test_backpressure();
    repeat (END_CYCLES) @(posedge clk);
    if (pending_reports.size() != 0)
      report_mismatch("results never arrived", 48'(pending_reports.size()), '0);
    if (mismatches == 0) begin
      $display("PASS dirty_page_range_scanner");
    end else begin
      $display("FAIL dirty_page_range_scanner");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dprs_pkg.sv
rtl/dprs_find.sv
rtl/dirty_page_range_scanner.sv
test/tb_top.sv
